// ===== hw/rtl/pdh_pkg.sv =====
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared constants, types and helpers of the pair difference histogram.
// ----------------------------------------------------------------------------
package pdh_pkg;

    localparam int MAX_DOTS    = 32;
    localparam int COUNT_BITS  = 16;

    localparam int SPAN        = 2 * MAX_DOTS + 1;
    localparam int VEC_DEPTH   = (MAX_DOTS - 1) * SPAN;
    localparam int COORD_DEPTH = MAX_DOTS * (MAX_DOTS + 1);
    localparam int CLR_DEPTH   = (VEC_DEPTH > COORD_DEPTH) ? VEC_DEPTH : COORD_DEPTH;

    localparam int COL_W       = $clog2(MAX_DOTS);
    localparam int CNT_W       = $clog2(MAX_DOTS + 1);
    localparam int ROW_W       = $clog2(MAX_DOTS + 1);
    localparam int SPAN_W      = $clog2(SPAN);
    localparam int VEC_AW      = $clog2(VEC_DEPTH);
    localparam int COORD_AW    = $clog2(COORD_DEPTH);
    localparam int AD_W        = (VEC_AW > COORD_AW) ? VEC_AW : COORD_AW;
    localparam int CLR_W       = $clog2(CLR_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // fixed field widths
    localparam int CMD_W       = 2;
    localparam int ROWIN_W     = 6;
    localparam int QCOL_W      = 5;
    localparam int QROW_W      = 7;
    localparam int EDOTS_W     = 6;
    localparam int SOL_W       = 16;
    localparam int TOTAL_W     = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VREAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CREAD   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SUMMARY = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_DOTS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SOLUTIONS = 2'd1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_VREAD,
        OP_CREAD,
        OP_SUMMARY
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_VECTOR  = 2'd1,
        KIND_COORD   = 2'd2,
        KIND_SUMMARY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUSH,
        ST_READ
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             in_range;
        logic [AD_W-1:0]  addr;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qlink;

    typedef struct packed {
        t_kind              kind;
        logic               mismatch;
        logic [TOTAL_W-1:0] count;
        logic [SOL_W-1:0]   sols;
    } t_result;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOTAL_W-1:0] clip24(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h00FF_FFFF) ? 24'hFF_FFFF : w[TOTAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pdh_ram.sv =====
// ----------------------------------------------------------------------------
// pdh_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pdh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pdh_front.sv =====
// ----------------------------------------------------------------------------
// pdh_front
// Input queue: takes items, decodes the command and precomputes read addresses.
// ----------------------------------------------------------------------------
module pdh_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [pdh_pkg::CMD_W-1:0] i_cmd,
    input  logic [pdh_pkg::ROWIN_W-1:0] i_row_value,
    input  logic                      i_last_dot,
    input  logic [pdh_pkg::QCOL_W-1:0] i_query_col,
    input  logic signed [pdh_pkg::QROW_W-1:0] i_query_row,
    input  logic                      i_hold,
    input  logic                      i_q_pop,
    output pdh_pkg::t_qlink           o_q
);
    import pdh_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    t_item             n_item;
    logic              accept;

    always_comb begin
        int qc;
        int qr;
        int rv;
        qc = int'(i_query_col);
        qr = int'(i_query_row);
        rv = int'(i_row_value);
        n_item          = '0;
        n_item.last     = i_last_dot;
        n_item.row      = (rv > MAX_DOTS) ? ROW_W'(MAX_DOTS) : ROW_W'(rv);
        case (i_cmd)
            CMD_PUSH: begin
                n_item.op = OP_PUSH;
            end
            CMD_VREAD: begin
                n_item.op       = OP_VREAD;
                n_item.in_range = (qc >= 1) && (qc < MAX_DOTS) &&
                                  (qr >= -MAX_DOTS) && (qr <= MAX_DOTS);
                if (n_item.in_range) begin
                    n_item.addr = AD_W'((qc - 1) * SPAN + (qr + MAX_DOTS));
                end
            end
            CMD_CREAD: begin
                n_item.op       = OP_CREAD;
                n_item.in_range = (qc < MAX_DOTS) && (qr >= 0) && (qr <= MAX_DOTS);
                if (n_item.in_range) begin
                    n_item.addr = AD_W'(qc * (MAX_DOTS + 1) + qr);
                end
            end
            default: begin
                n_item.op = OP_SUMMARY;
            end
        endcase
    end

    assign full   = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH)) || i_hold;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(accept) - (QPTR_W + 1)'(i_q_pop);
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.item  = r_mem[r_rd];

endmodule

// ===== hw/rtl/pdh_back.sv =====
// ----------------------------------------------------------------------------
// pdh_back
// Execution engine: histogram updates, pair loop, reads and result register.
// ----------------------------------------------------------------------------
module pdh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdh_pkg::t_qlink               i_q,
    output logic                          o_q_pop,
    output logic                          o_clearing,
    input  logic [pdh_pkg::EDOTS_W-1:0]   i_exp_dots,
    input  logic [pdh_pkg::SOL_W-1:0]     i_exp_sols,
    input  logic                          i_res_pop,
    output logic                          o_res_valid,
    output pdh_pkg::t_result              o_res
);
    import pdh_pkg::*;

    t_state               r_state, n_state;
    logic [CLR_W-1:0]     r_clr_addr;
    logic [CNT_W-1:0]     r_col;
    logic                 r_ovf;
    logic [SOL_W-1:0]     r_sol_total;
    logic [TOTAL_W-1:0]   r_dot_total;
    t_item                r_item;
    logic [CNT_W-1:0]     r_j;
    logic                 r_s1_v;
    logic [COL_W-1:0]     r_s1_dxm1;
    logic                 r_s2_v;
    logic [VEC_AW-1:0]    r_s2_addr;
    logic                 r_coord_pend;
    logic [COORD_AW-1:0]  r_coord_addr;
    logic                 r_res_valid;
    t_result              r_res;

    logic                 start, room, clr_last, push_done, issue;
    logic                 fin, fin_last, fin_ovf;
    logic [CNT_W-1:0]     fin_col;
    logic [SOL_W-1:0]     sol_inc;
    logic                 res_set;
    t_result              res_next;

    logic [VEC_AW-1:0]    vec_addr_s1;
    logic [SPAN_W-1:0]    dy_off;
    logic [COORD_AW-1:0]  coord_push_addr;

    logic                 dot_we;
    logic [COL_W-1:0]     dot_waddr, dot_raddr;
    logic [ROW_W-1:0]     dot_rdata;
    logic                 vec_we;
    logic [VEC_AW-1:0]    vec_waddr, vec_raddr;
    logic [COUNT_BITS-1:0] vec_wdata, vec_rdata;
    logic                 coord_we;
    logic [COORD_AW-1:0]  coord_waddr, coord_raddr;
    logic [COUNT_BITS-1:0] coord_wdata, coord_rdata;

    assign start    = (r_state == ST_IDLE) && i_q.valid && !r_res_valid;
    assign room     = r_col < CNT_W'(MAX_DOTS);
    assign clr_last = r_clr_addr == CLR_W'(CLR_DEPTH - 1);
    assign issue    = (r_state == ST_PUSH) && (r_j < r_col);
    assign push_done = (r_state == ST_PUSH) && (r_j == r_col) && !r_s1_v && !r_s2_v &&
                       !r_coord_pend;

    assign dy_off      = SPAN_W'(int'(r_item.row) + MAX_DOTS - int'(dot_rdata));
    assign vec_addr_s1 = VEC_AW'(r_s1_dxm1) * VEC_AW'(SPAN) + VEC_AW'(dy_off);
    assign coord_push_addr = COORD_AW'(r_col) * COORD_AW'(MAX_DOTS + 1) +
                             COORD_AW'(i_q.item.row);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_q.item.op)
                        OP_PUSH:  n_state = room ? ST_PUSH : ST_IDLE;
                        OP_VREAD: n_state = ST_READ;
                        OP_CREAD: n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH: begin
                if (push_done) n_state = ST_IDLE;
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs: memory control, finish and result
    always_comb begin
        logic [COUNT_BITS-1:0] rd;
        rd          = '0;
        o_q_pop     = start;
        o_clearing  = (r_state == ST_CLEAR);
        dot_we      = start && (i_q.item.op == OP_PUSH) && room;
        dot_waddr   = r_col[COL_W-1:0];
        dot_raddr   = r_j[COL_W-1:0];
        vec_we      = 1'b0;
        vec_waddr   = r_s2_addr;
        vec_wdata   = sat_inc(vec_rdata);
        vec_raddr   = i_q.item.addr[VEC_AW-1:0];
        coord_we    = 1'b0;
        coord_waddr = r_coord_addr;
        coord_wdata = sat_inc(coord_rdata);
        coord_raddr = (i_q.item.op == OP_PUSH) ? coord_push_addr
                                               : i_q.item.addr[COORD_AW-1:0];
        fin         = 1'b0;
        fin_last    = r_item.last;
        fin_ovf     = r_ovf;
        fin_col     = r_col + 1'b1;
        sol_inc     = (r_sol_total == '1) ? r_sol_total : r_sol_total + 1'b1;
        res_set     = 1'b0;
        res_next    = '0;
        res_next.sols = r_sol_total;

        case (r_state)
            ST_CLEAR: begin
                vec_we      = 1'b1;
                vec_waddr   = VEC_AW'(r_clr_addr);
                vec_wdata   = '0;
                coord_we    = r_clr_addr < CLR_W'(COORD_DEPTH);
                coord_waddr = COORD_AW'(r_clr_addr);
                coord_wdata = '0;
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_q.item.op)
                        OP_PUSH: begin
                            if (!room) begin
                                fin      = 1'b1;
                                fin_last = i_q.item.last;
                                fin_ovf  = 1'b1;
                                fin_col  = r_col;
                            end
                        end
                        OP_SUMMARY: begin
                            res_set           = 1'b1;
                            res_next.kind     = KIND_SUMMARY;
                            res_next.mismatch = r_sol_total != i_exp_sols;
                            res_next.count    = r_dot_total;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                vec_raddr = vec_addr_s1;
                vec_we    = r_s2_v;
                coord_we  = r_coord_pend;
                fin       = push_done;
            end
            ST_READ: begin
                rd = (r_item.op == OP_VREAD) ? vec_rdata : coord_rdata;
                res_set        = 1'b1;
                res_next.kind  = (r_item.op == OP_VREAD) ? KIND_VECTOR : KIND_COORD;
                res_next.count = r_item.in_range ? clip24(rd) : '0;
            end
            default: begin
            end
        endcase

        if (fin && fin_last) begin
            res_set           = 1'b1;
            res_next.kind     = KIND_STATUS;
            res_next.mismatch = fin_ovf || (32'(fin_col) != 32'(i_exp_dots));
            res_next.count    = TOTAL_W'(fin_col);
            res_next.sols     = sol_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_col        <= '0;
            r_ovf        <= 1'b0;
            r_sol_total  <= '0;
            r_dot_total  <= '0;
            r_j          <= '0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            r_coord_pend <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (start) begin
                r_j          <= '0;
                r_coord_pend <= (i_q.item.op == OP_PUSH) && room;
            end else if (r_state == ST_PUSH) begin
                r_coord_pend <= 1'b0;
            end
            if (issue) begin
                r_j <= r_j + 1'b1;
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v && (r_state == ST_PUSH);
            if (fin) begin
                if (fin_last) begin
                    r_col       <= '0;
                    r_ovf       <= 1'b0;
                    r_sol_total <= sol_inc;
                end else begin
                    r_col <= fin_col;
                    r_ovf <= fin_ovf;
                end
            end
            if (push_done && r_dot_total != '1) begin
                r_dot_total <= r_dot_total + 1'b1;
            end
            if (res_set) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item       <= i_q.item;
            r_coord_addr <= coord_push_addr;
        end
        r_s1_dxm1 <= COL_W'(r_col - r_j - 1'b1);
        r_s2_addr <= vec_addr_s1;
        if (res_set) begin
            r_res <= res_next;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    pdh_ram #(.WIDTH(ROW_W), .DEPTH(MAX_DOTS)) u_dot_ram (
        .i_clk   (i_clk),
        .i_we    (dot_we),
        .i_waddr (dot_waddr),
        .i_wdata (i_q.item.row),
        .i_raddr (dot_raddr),
        .o_rdata (dot_rdata)
    );

    pdh_ram #(.WIDTH(COUNT_BITS), .DEPTH(VEC_DEPTH)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (vec_wdata),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    pdh_ram #(.WIDTH(COUNT_BITS), .DEPTH(COORD_DEPTH)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (coord_we),
        .i_waddr (coord_waddr),
        .i_wdata (coord_wdata),
        .i_raddr (coord_raddr),
        .o_rdata (coord_rdata)
    );

endmodule

// ===== hw/rtl/pair_difference_histogram.sv =====
// ----------------------------------------------------------------------------
// pair_difference_histogram
// Coordinate and difference-vector histograms over permutation-array solutions.
// ----------------------------------------------------------------------------
// after reset the block runs a clearing pass over both count memories, stepping
// through as many addresses as the vector memory is deep; full stays high meanwhile.
// items enter a 4-deep input queue and are executed one at a time. a pushed dot
// goes through a start step, a pair loop over the earlier dots of its solution,
// which reads one earlier row from the dot-row memory and does one
// read-modify-write of the vector memory per cycle, a drain of the s1 and s2
// pipeline registers and a finish step. a dot beyond the maximum is not stored
// and only marks the overflow; reads pass through a read state and a summary
// is answered from the idle state.
// a result waits in an output register while the queue keeps taking items.
module pair_difference_histogram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input side
    input  logic                                push,
    output logic                                full,
    input  logic [pdh_pkg::CMD_W-1:0]           i_cmd,
    input  logic [pdh_pkg::ROWIN_W-1:0]         i_row_value,
    input  logic                                i_last_dot,
    input  logic [pdh_pkg::QCOL_W-1:0]          i_query_col,
    input  logic signed [pdh_pkg::QROW_W-1:0]   i_query_row,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          o_kind,
    output logic                                o_mismatch,
    output logic [pdh_pkg::TOTAL_W-1:0]         o_count_value,
    output logic [pdh_pkg::SOL_W-1:0]           o_solutions_seen,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pdh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pdh_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import pdh_pkg::*;

    logic [EDOTS_W-1:0] r_exp_dots;
    logic [SOL_W-1:0]   r_exp_sols;
    t_qlink             q;
    logic               q_pop;
    logic               clearing;
    logic               res_valid;
    t_result            res;

    // configuration registers, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_dots <= EDOTS_W'(MAX_DOTS);
            r_exp_sols <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EXPECTED_DOTS:      r_exp_dots <= i_cfg_wdata[EDOTS_W-1:0];
                REG_EXPECTED_SOLUTIONS: r_exp_sols <= i_cfg_wdata[SOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: takes and decodes items
    pdh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_row_value (i_row_value),
        .i_last_dot  (i_last_dot),
        .i_query_col (i_query_col),
        .i_query_row (i_query_row),
        .i_hold      (clearing),
        .i_q_pop     (q_pop),
        .o_q         (q)
    );

    // back: histogram updates and results
    pdh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .i_exp_dots  (r_exp_dots),
        .i_exp_sols  (r_exp_sols),
        .i_res_pop   (pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result transfer
    assign empty            = !res_valid;
    assign o_kind           = res.kind;
    assign o_mismatch       = res.mismatch;
    assign o_count_value    = res.count;
    assign o_solutions_seen = res.sols;

endmodule

// ===== hw/rtl/pdh_checker.sv =====
// ----------------------------------------------------------------------------
// pdh_checker
// Port-level checks of the pair difference histogram.
// ----------------------------------------------------------------------------
module pdh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [1:0]                  o_kind,
    input logic                        o_mismatch,
    input logic [pdh_pkg::TOTAL_W-1:0] o_count_value
);
    import pdh_pkg::*;

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (full && empty))
        else $error("queue sides not closed after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_count_value))
        else $error("waiting result changed");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_VECTOR || o_kind == KIND_COORD)) |->
        (!o_mismatch && 32'(o_count_value) <= 32'((64'd1 << COUNT_BITS) - 1)))
        else $error("read result out of range");

endmodule

bind pair_difference_histogram pdh_checker u_pdh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_kind        (o_kind),
    .o_mismatch    (o_mismatch),
    .o_count_value (o_count_value)
);
